// File: hw/rtl/sacr_pkg.sv
`default_nettype none

package sacr_pkg;

    localparam int RAW_W = 8;
    localparam int MAG_W = 8;
    localparam int AXIS_W = 7;
    localparam int FACTOR_W = 5;
    localparam int PROD_W = MAG_W + FACTOR_W;
    localparam int BOOST_W = 2 * AXIS_W;

    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] REG_WIDE_MODE = 3'd2;
    localparam logic [2:0] REG_LEGACY_MODE = 3'd3;
    localparam logic [2:0] REG_DEADZONE_ON = 3'd4;

    localparam logic [MAG_W-1:0] DEADZONE_SIZE = 8'd12;
    localparam logic [MAG_W-1:0] AXIS_LIMIT = 8'd127;
    localparam logic [MAG_W-1:0] LIMIT_NEW = 8'd80;
    localparam logic [MAG_W-1:0] LIMIT_OLD = 8'd127;

    // mult / 32000 reduced to k / 32
    localparam logic [FACTOR_W-1:0] FACTOR_NEW = 5'd26;
    localparam logic [FACTOR_W-1:0] FACTOR_OLD = 5'd25;
    localparam logic [FACTOR_W-1:0] FACTOR_DZ_NEW = 5'd30;
    localparam logic [FACTOR_W-1:0] FACTOR_DZ_OLD = 5'd29;

    typedef struct packed {
        logic wide;
        logic legacy;
        logic deadzone;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/sacr_axis.sv
`default_nettype none

module sacr_axis (
    input  wire logic                            clk,
    input  wire sacr_pkg::cfg_t                  cfg,
    input  wire logic [sacr_pkg::RAW_W-1:0]      raw,
    input  wire logic signed [sacr_pkg::RAW_W-1:0] origin,
    output logic [sacr_pkg::AXIS_W-1:0]          mag,
    output logic                                 neg
);

    logic signed [sacr_pkg::RAW_W:0] diff;
    logic [sacr_pkg::RAW_W:0]        diff_neg;
    logic [sacr_pkg::MAG_W-1:0]      abs_val;
    logic [sacr_pkg::MAG_W-1:0]      mag1_next;
    logic [sacr_pkg::MAG_W-1:0]      mag1_reg;
    logic                            neg1_reg;
    logic [sacr_pkg::FACTOR_W-1:0]   factor;
    logic [sacr_pkg::PROD_W-1:0]     prod;
    logic [sacr_pkg::MAG_W-1:0]      scaled;
    logic [sacr_pkg::AXIS_W-1:0]     mag2_next;
    logic [sacr_pkg::AXIS_W-1:0]     mag2_reg;
    logic                            neg2_reg;

    // flip offset binary to signed, subtract origin, apply dead zone
    always_comb
    begin
        diff = {~raw[sacr_pkg::RAW_W-1], ~raw[sacr_pkg::RAW_W-1], raw[sacr_pkg::RAW_W-2:0]}
               - {origin[sacr_pkg::RAW_W-1], origin};
        diff_neg = -diff;
        abs_val = diff[sacr_pkg::RAW_W] ? diff_neg[sacr_pkg::MAG_W-1:0]
                                        : diff[sacr_pkg::MAG_W-1:0];
        mag1_next = abs_val;
        if (cfg.deadzone)
        begin
            if (abs_val < sacr_pkg::DEADZONE_SIZE)
                mag1_next = '0;
            else
                mag1_next = abs_val - sacr_pkg::DEADZONE_SIZE;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag1_next;
        neg1_reg <= diff[sacr_pkg::RAW_W];
    end

    // scale by k/32 on the magnitude (bypassed in wide mode), truncating toward zero, then clamp
    always_comb
    begin
        case ({cfg.legacy, cfg.deadzone})
            2'b00:   factor = sacr_pkg::FACTOR_NEW;
            2'b10:   factor = sacr_pkg::FACTOR_OLD;
            2'b01:   factor = sacr_pkg::FACTOR_DZ_NEW;
            2'b11:   factor = sacr_pkg::FACTOR_DZ_OLD;
            default: factor = sacr_pkg::FACTOR_NEW;
        endcase
        prod = sacr_pkg::PROD_W'(mag1_reg) * sacr_pkg::PROD_W'(factor);
        scaled = cfg.wide ? mag1_reg : prod[sacr_pkg::PROD_W-1:sacr_pkg::FACTOR_W];
        if (scaled > sacr_pkg::AXIS_LIMIT)
            mag2_next = sacr_pkg::AXIS_LIMIT[sacr_pkg::AXIS_W-1:0];
        else
            mag2_next = scaled[sacr_pkg::AXIS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        mag2_reg <= mag2_next;
        neg2_reg <= neg1_reg;
    end

    assign mag = mag2_reg;
    assign neg = neg2_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sacr_boost.sv
`default_nettype none

module sacr_boost (
    input  wire logic                              clk,
    input  wire sacr_pkg::cfg_t                    cfg,
    input  wire logic [sacr_pkg::AXIS_W-1:0]       mag,
    input  wire logic                              neg,
    input  wire logic [sacr_pkg::AXIS_W-1:0]       other_mag,
    output logic signed [sacr_pkg::MAG_W-1:0]      out_val
);

    logic [sacr_pkg::BOOST_W-1:0]  prod;
    logic [sacr_pkg::MAG_W-1:0]    quot;
    logic [sacr_pkg::MAG_W-1:0]    sum;
    logic [sacr_pkg::MAG_W-1:0]    lim;
    logic [sacr_pkg::MAG_W-1:0]    res_mag;
    logic [sacr_pkg::MAG_W-1:0]    out_next;
    logic [sacr_pkg::MAG_W-1:0]    out_reg;

    // boost the magnitude by mag * |other| / L, clamp to the mode limit; wide mode passes it unchanged
    always_comb
    begin
        prod = sacr_pkg::BOOST_W'(mag) * sacr_pkg::BOOST_W'(other_mag);
        if (cfg.legacy)
        begin
            quot = sacr_pkg::MAG_W'(prod[sacr_pkg::BOOST_W-1:9]);
            lim = sacr_pkg::LIMIT_OLD;
        end
        else
        begin
            quot = sacr_pkg::MAG_W'(prod[sacr_pkg::BOOST_W-1:8]);
            lim = sacr_pkg::LIMIT_NEW;
        end
        sum = sacr_pkg::MAG_W'(mag) + quot;
        if (cfg.wide)
            res_mag = sacr_pkg::MAG_W'(mag);
        else if (sum > lim)
            res_mag = lim;
        else
            res_mag = sum;
        out_next = neg ? -res_mag : res_mag;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_val = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stick_axis_calibrate_and_reshape_top.sv
// Converts one raw offset-binary X/Y stick sample pair per transfer into signed
// axis values in -127..127. A sample is taken on every clock edge with start high
// (busy is always low), and its result passes the stages below and appears
// on out_x/out_y for one cycle, marked by done; results cannot be held off, so
// capture them when done is high. Throughput is one sample per cycle, set by a
// three-stage pipeline: origin and dead zone, scaling and clamp, cross-axis boost.
// Write configuration registers (0 x_origin, 1 y_origin, 2 wide_mode,
// 3 legacy_mode, 4 deadzone_on) through the cfg port only while no sample is in
// flight; writes to other indexes are ignored.
`default_nettype none

module stick_axis_calibrate_and_reshape_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [sacr_pkg::RAW_W-1:0]        raw_x,
    input  wire logic [sacr_pkg::RAW_W-1:0]        raw_y,
    output logic                                   done,
    output logic signed [sacr_pkg::MAG_W-1:0]      out_x,
    output logic signed [sacr_pkg::MAG_W-1:0]      out_y,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [sacr_pkg::RAW_W-1:0]        cfg_data
);

    logic signed [sacr_pkg::RAW_W-1:0] x_origin_reg;
    logic signed [sacr_pkg::RAW_W-1:0] y_origin_reg;
    sacr_pkg::cfg_t                    cfg_reg;
    logic [2:0]                        valid_reg;
    logic [2:0]                        valid_next;
    logic [sacr_pkg::AXIS_W-1:0]       mag_x;
    logic [sacr_pkg::AXIS_W-1:0]       mag_y;
    logic                              neg_x;
    logic                              neg_y;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sacr_pkg::REG_X_ORIGIN:    x_origin_reg <= cfg_data;
                sacr_pkg::REG_Y_ORIGIN:    y_origin_reg <= cfg_data;
                sacr_pkg::REG_WIDE_MODE:   cfg_reg.wide <= cfg_data[0];
                sacr_pkg::REG_LEGACY_MODE: cfg_reg.legacy <= cfg_data[0];
                sacr_pkg::REG_DEADZONE_ON: cfg_reg.deadzone <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // advance the valid bits alongside the data stages
    assign valid_next = {valid_reg[1:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    sacr_axis u_axis_x (
        .clk    (clk),
        .cfg    (cfg_reg),
        .raw    (raw_x),
        .origin (x_origin_reg),
        .mag    (mag_x),
        .neg    (neg_x)
    );

    sacr_axis u_axis_y (
        .clk    (clk),
        .cfg    (cfg_reg),
        .raw    (raw_y),
        .origin (y_origin_reg),
        .mag    (mag_y),
        .neg    (neg_y)
    );

    sacr_boost u_boost_x (
        .clk       (clk),
        .cfg       (cfg_reg),
        .mag       (mag_x),
        .neg       (neg_x),
        .other_mag (mag_y),
        .out_val   (out_x)
    );

    sacr_boost u_boost_y (
        .clk       (clk),
        .cfg       (cfg_reg),
        .mag       (mag_y),
        .neg       (neg_y),
        .other_mag (mag_x),
        .out_val   (out_y)
    );

    assign done = valid_reg[2];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("accepted sample did not complete after three cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[1]) && $past(valid_reg[0], 2))
        else $error("result strobe without a sample in flight");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_x != 8'sh80 && out_y != 8'sh80)
        else $error("result outside symmetric range");

endmodule

`default_nettype wire

// File: tb/tb_stick_axis_calibrate_and_reshape_top.sv
`timescale 1ns / 100ps

module tb_stick_axis_calibrate_and_reshape_top;

    import sacr_pkg::*;

    localparam int MULT_NEW = 26000;
    localparam int MULT_OLD = 25000;
    localparam int MULT_DZ_NEW = 30000;
    localparam int MULT_DZ_OLD = 29000;
    localparam int SCALE_DIV = 32000;
    localparam int DEAD_ZONE = 12;
    localparam int AXIS_MAX = 127;
    localparam int BOOST_DIV_NEW = 256;
    localparam int BOOST_DIV_OLD = 512;
    localparam int BOOST_MAX_NEW = 80;
    localparam int BOOST_MAX_OLD = 127;
    localparam logic [2:0] REG_COUNT = 3'd5;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 18;
    localparam int PHASE_SAMPLES = 105;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
    } raw_pair_t;

    typedef struct packed {
        logic signed [MAG_W-1:0] x;
        logic signed [MAG_W-1:0] y;
    } axis_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [RAW_W-1:0] raw_x = '0;
    logic [RAW_W-1:0] raw_y = '0;
    logic done;
    logic signed [MAG_W-1:0] out_x;
    logic signed [MAG_W-1:0] out_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [RAW_W-1:0] cfg_data = '0;

    raw_pair_t raw_samples[$];
    axis_pair_t pending_axes[$];

    logic signed [MAG_W-1:0] x_center = '0;
    logic signed [MAG_W-1:0] y_center = '0;
    cfg_t modes = '0;

    int sender_idle_pct = 0;
    bit sender_hold = 1'b0;
    bit took_sample = 1'b0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    stick_axis_calibrate_and_reshape_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .raw_x(raw_x),
        .raw_y(raw_y),
        .done(done),
        .out_x(out_x),
        .out_y(out_y),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: mismatch: %0s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int clip_sym(input int v, input int lim);
        if (v <= -lim)
            return -lim;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int calibrate_axis(input logic signed [MAG_W-1:0] center,
                                          input logic [RAW_W-1:0] raw);
        int v;
        int mult;
        v = int'($signed(raw ^ 8'h80)) - int'(center);
        mult = modes.legacy ? MULT_OLD : MULT_NEW;
        if (modes.deadzone)
        begin
            mult = modes.legacy ? MULT_DZ_OLD : MULT_DZ_NEW;
            if (v > 0)
                v = (v < DEAD_ZONE) ? 0 : v - DEAD_ZONE;
            else if (v < 0)
                v = (v > -DEAD_ZONE) ? 0 : v + DEAD_ZONE;
        end
        if (!modes.wide)
            v = v * mult / SCALE_DIV;
        return clip_sym(v, AXIS_MAX);
    endfunction

    function automatic axis_pair_t predict_axes(input logic [RAW_W-1:0] rx,
                                                input logic [RAW_W-1:0] ry);
        int sx;
        int sy;
        int bx;
        int by;
        int div;
        int lim;
        axis_pair_t pair;
        sx = calibrate_axis(x_center, rx);
        sy = calibrate_axis(y_center, ry);
        if (!modes.wide)
        begin
            div = modes.legacy ? BOOST_DIV_OLD : BOOST_DIV_NEW;
            lim = modes.legacy ? BOOST_MAX_OLD : BOOST_MAX_NEW;
            bx = sx + sx * (sy < 0 ? -sy : sy) / div;
            by = sy + sy * (sx < 0 ? -sx : sx) / div;
            sx = clip_sym(bx, lim);
            sy = clip_sym(by, lim);
        end
        pair.x = 8'(sx);
        pair.y = 8'(sy);
        return pair;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw(input logic signed [MAG_W-1:0] center);
        case ($urandom_range(3))
            0: return 8'($urandom);
            1: return 8'(8'h80 + center + $urandom_range(32) - 16);
            2:
            begin
                case ($urandom_range(4))
                    0: return 8'h00;
                    1: return 8'hff;
                    2: return 8'h7f;
                    3: return 8'h80;
                    default: return 8'h81;
                endcase
            end
            default: return 8'(8'h80 + $urandom_range(60) - 30);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [RAW_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setup(input logic signed [MAG_W-1:0] xo,
                               input logic signed [MAG_W-1:0] yo,
                               input cfg_t m);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_WIDE_MODE, {7'($urandom), m.wide});
        write_reg(REG_LEGACY_MODE, {7'($urandom), m.legacy});
        write_reg(REG_DEADZONE_ON, {7'($urandom), m.deadzone});
        // out-of-range index must leave every register alone
        if ($urandom_range(2) == 0)
            write_reg(REG_COUNT + 3'($urandom_range(2)), 8'($urandom));
    endtask

    task automatic queue_edge_samples();
        raw_samples.push_back('{8'h00, 8'h00});
        raw_samples.push_back('{8'hff, 8'hff});
        raw_samples.push_back('{8'h80, 8'h80});
        raw_samples.push_back('{8'h00, 8'hff});
        raw_samples.push_back('{8'hff, 8'h80});
        raw_samples.push_back('{8'h8b, 8'h75});
        raw_samples.push_back('{8'h8c, 8'h74});
        raw_samples.push_back('{8'h8d, 8'h73});
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (raw_samples.size() != 0 || start || pending_axes.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        raw_pair_t s;
        if (rst_n && (!start || took_sample))
        begin
            if (raw_samples.size() != 0 && !sender_hold
                && $urandom_range(99) >= sender_idle_pct)
            begin
                s = raw_samples.pop_front();
                start <= 1'b1;
                raw_x <= s.x;
                raw_y <= s.y;
            end
            else
            begin
                start <= 1'b0;
                raw_x <= 8'($urandom);
                raw_y <= 8'($urandom);
            end
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        axis_pair_t want;
        bit moved;
        moved = 1'b0;
        took_sample = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                moved = 1'b1;
                if (pending_axes.size() == 0)
                    flag_mismatch($sformatf("unexpected result x=%0d y=%0d", out_x, out_y));
                else
                begin
                    want = pending_axes.pop_front();
                    if (out_x !== want.x)
                        flag_mismatch($sformatf("out_x got %0d want %0d", out_x, want.x));
                    if (out_y !== want.y)
                        flag_mismatch($sformatf("out_y got %0d want %0d", out_y, want.y));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    REG_X_ORIGIN: x_center = cfg_data;
                    REG_Y_ORIGIN: y_center = cfg_data;
                    REG_WIDE_MODE: modes.wide = cfg_data[0];
                    REG_LEGACY_MODE: modes.legacy = cfg_data[0];
                    REG_DEADZONE_ON: modes.deadzone = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                took_sample = 1'b1;
                pending_axes.push_back(predict_axes(raw_x, raw_y));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [MAG_W-1:0] xo;
        logic signed [MAG_W-1:0] yo;
        cfg_t m;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults, then the far-origin corners
        queue_edge_samples();
        drain();
        m = '{wide: 1'b0, legacy: 1'b1, deadzone: 1'b1};
        apply_setup(8'h80, 8'h7f, m);
        queue_edge_samples();
        drain();
        m = '{wide: 1'b1, legacy: 1'b0, deadzone: 1'b1};
        apply_setup(8'h7f, 8'h80, m);
        queue_edge_samples();
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            m = (p < 8) ? cfg_t'(p) : cfg_t'($urandom);
            if (p % 10 == 0)
            begin
                xo = 8'h80;
                yo = 8'h7f;
            end
            else if (p % 10 == 5)
            begin
                xo = 8'h7f;
                yo = 8'h80;
            end
            else if (p % 5 == 1)
            begin
                xo = 8'($urandom);
                yo = 8'($urandom);
            end
            else
            begin
                xo = 8'($urandom_range(40) - 20);
                yo = 8'($urandom_range(40) - 20);
            end
            apply_setup(xo, yo, m);
            case (p % 3)
                0: sender_idle_pct <= 0;
                1: sender_idle_pct <= 50;
                default: sender_idle_pct <= 20;
            endcase
            for (int i = 0; i < PHASE_SAMPLES; i++)
                raw_samples.push_back('{pick_raw(xo), pick_raw(yo)});
            if (p % 4 == 2)
            begin
                // hold the sender until the pipeline has emptied
                do
                    @(negedge clk);
                while (raw_samples.size() > PHASE_SAMPLES / 2);
                sender_hold <= 1'b1;
                do
                    @(negedge clk);
                while (start || pending_axes.size() != 0);
                sender_hold <= 1'b0;
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_axes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sacr_pkg.sv
hw/rtl/sacr_axis.sv
hw/rtl/sacr_boost.sv
hw/rtl/stick_axis_calibrate_and_reshape_top.sv
tb/tb_stick_axis_calibrate_and_reshape_top.sv
